/* hdl/bsft_pkg.sv */
// ----------------------------------------------------------------------------
// bsft_pkg
// Types and codes shared by the sorted floor table and its cells.
// ----------------------------------------------------------------------------
`default_nettype none

package bsft_pkg;

	localparam int KEY_W    = 64;
	localparam int HANDLE_W = 32;
	localparam int LIMIT_W  = 5;

	localparam logic [LIMIT_W-1:0] LIMIT_RST = 5'd16;

	localparam logic ACT_PUT    = 1'b0;
	localparam logic ACT_LOOKUP = 1'b1;

	localparam logic [2:0] OP_HOLD    = 3'd0;
	localparam logic [2:0] OP_INSERT  = 3'd1;
	localparam logic [2:0] OP_DROP    = 3'd2;
	localparam logic [2:0] OP_REPLACE = 3'd3;
	localparam logic [2:0] OP_SHIFT   = 3'd4;

	typedef struct packed {
		logic [KEY_W-1:0]    key;
		logic [HANDLE_W-1:0] handle;
	} bsft_entry_t;

	typedef struct packed {
		logic [2:0]          op;
		logic [KEY_W-1:0]    key;
		logic [HANDLE_W-1:0] handle;
	} bsft_bus_t;

endpackage

`default_nettype wire

/* hdl/bsft_cell.sv */
// ----------------------------------------------------------------------------
// bsft_cell
// One slot of the sorted row: compares its key with the broadcast key and
// takes its next entry from itself, a neighbor or the broadcast beat.
// ----------------------------------------------------------------------------
`default_nettype none

module bsft_cell
	import bsft_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        occ,
	input  wire bsft_bus_t   bus,
	input  wire bsft_entry_t left_entry,
	input  wire bsft_entry_t right_entry,
	input  wire logic        left_lt,
	input  wire logic        right_lt,
	input  wire logic        right_le,
	output bsft_entry_t      entry,
	output logic             lt,
	output logic             le,
	output logic             eq,
	output bsft_entry_t      hit_entry
);

	bsft_entry_t entry_q;
	bsft_entry_t new_entry;

	assign new_entry = '{key: bus.key, handle: bus.handle};
	assign entry     = entry_q;

	assign lt = occ && ($signed(entry_q.key) <  $signed(bus.key));
	assign le = occ && ($signed(entry_q.key) <= $signed(bus.key));
	assign eq = occ && (entry_q.key == bus.key);

	assign hit_entry = (le && !right_le) ? entry_q : '0;

	always_ff @(posedge clk) begin
		case (bus.op)
			OP_INSERT: begin
				if (!lt) entry_q <= left_lt ? new_entry : left_entry;
			end
			OP_DROP: begin
				if (right_lt) entry_q <= right_entry;
				else if (lt) entry_q <= new_entry;
			end
			OP_REPLACE: begin
				if (eq) entry_q <= new_entry;
			end
			OP_SHIFT: begin
				entry_q <= right_entry;
			end
			default: begin
				entry_q <= entry_q;
			end
		endcase
	end

endmodule

`default_nettype wire

/* hdl/bounded_sorted_floor_table.sv */
// ----------------------------------------------------------------------------
// bounded_sorted_floor_table
// Sorted table of up to CAPACITY keyed entries with floor lookup.
// ----------------------------------------------------------------------------
// Lookup: one compare over every cell at once, registered from the run state.
// Put: the run state inserts, replaces, or drops the lowest key when full;
//   evict sheds lowest entries to the limit; a zero limit keeps the table.
// One beat at a time; busy is high from accept until the cycle before done.
// Reset empties the table and sets the limit to 16; results cannot stall.
`default_nettype none

module bounded_sorted_floor_table
	import bsft_pkg::*;
#(
	parameter int CAPACITY = 16
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	output logic                     busy,
	input  wire logic                action,
	input  wire logic [KEY_W-1:0]    entry_key,
	input  wire logic [HANDLE_W-1:0] entry_handle,
	input  wire logic                cfg_we,
	input  wire logic [LIMIT_W-1:0]  cfg_wdata,
	output logic                     done,
	output logic                     found,
	output logic [KEY_W-1:0]         found_id,
	output logic [HANDLE_W-1:0]      found_handle,
	output logic [LIMIT_W-1:0]       entry_count
);

	localparam int CW = $clog2(CAPACITY + 1);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_RUN   = 2'd1;
	localparam logic [1:0] ST_EVICT = 2'd2;

	logic [1:0]          state_q;
	logic                req_action_q;
	logic [KEY_W-1:0]    req_key_q;
	logic [HANDLE_W-1:0] req_handle_q;
	logic [CW-1:0]       count_q;
	logic [LIMIT_W-1:0]  limit_q;
	logic                done_q;
	logic                found_q;
	logic [KEY_W-1:0]    found_id_q;
	logic [HANDLE_W-1:0] found_handle_q;
	logic [LIMIT_W-1:0]  entry_count_q;

	logic [CW-1:0] lim;
	logic          any_eq;
	logic          full;
	logic [2:0]    op;
	bsft_bus_t     bus;
	bsft_entry_t   hit_or;

	bsft_entry_t ent   [CAPACITY];
	bsft_entry_t hit_e [CAPACITY];
	logic [CAPACITY-1:0] lt_v;
	logic [CAPACITY-1:0] le_v;
	logic [CAPACITY-1:0] eq_v;

	assign lim    = (int'(limit_q) > CAPACITY) ? CW'(CAPACITY) : CW'(limit_q);
	assign any_eq = |eq_v;
	assign full   = (count_q == CW'(CAPACITY));

	always_comb begin
		op = OP_HOLD;
		if (state_q == ST_RUN && req_action_q == ACT_PUT && lim != '0) begin
			if (any_eq) op = OP_REPLACE;
			else if (full) op = OP_DROP;
			else op = OP_INSERT;
		end else if (state_q == ST_EVICT && count_q > lim) begin
			op = OP_SHIFT;
		end
	end

	assign bus = '{op: op, key: req_key_q, handle: req_handle_q};

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		bsft_entry_t left_e;
		bsft_entry_t right_e;
		logic        left_lt_w;
		logic        right_lt_w;
		logic        right_le_w;

		if (i == 0) begin : g_first
			assign left_e    = '0;
			assign left_lt_w = 1'b1;
		end else begin : g_mid_l
			assign left_e    = ent[i-1];
			assign left_lt_w = lt_v[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign right_e    = '0;
			assign right_lt_w = 1'b0;
			assign right_le_w = 1'b0;
		end else begin : g_mid_r
			assign right_e    = ent[i+1];
			assign right_lt_w = lt_v[i+1];
			assign right_le_w = le_v[i+1];
		end

		bsft_cell u_cell (
			.clk         (clk),
			.occ         (count_q > CW'(i)),
			.bus         (bus),
			.left_entry  (left_e),
			.right_entry (right_e),
			.left_lt     (left_lt_w),
			.right_lt    (right_lt_w),
			.right_le    (right_le_w),
			.entry       (ent[i]),
			.lt          (lt_v[i]),
			.le          (le_v[i]),
			.eq          (eq_v[i]),
			.hit_entry   (hit_e[i])
		);
	end

	always_comb begin
		hit_or = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			hit_or = hit_or | hit_e[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			limit_q <= LIMIT_RST;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cfg_we) limit_q <= cfg_wdata;
			case (state_q)
				ST_IDLE: begin
					if (start) state_q <= ST_RUN;
				end
				ST_RUN: begin
					if (req_action_q == ACT_LOOKUP || lim == '0) begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						if (!any_eq && !full) count_q <= count_q + CW'(1);
						state_q <= ST_EVICT;
					end
				end
				ST_EVICT: begin
					if (count_q > lim) begin
						count_q <= count_q - CW'(1);
					end else begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			req_action_q <= action;
			req_key_q    <= entry_key;
			req_handle_q <= entry_handle;
		end
		entry_count_q <= LIMIT_W'(count_q);
		if (state_q == ST_RUN && req_action_q == ACT_LOOKUP) begin
			found_q        <= |le_v;
			found_id_q     <= hit_or.key;
			found_handle_q <= hit_or.handle;
		end else begin
			found_q        <= 1'b0;
			found_id_q     <= '0;
			found_handle_q <= '0;
		end
	end

	assign busy         = (state_q != ST_IDLE);
	assign done         = done_q;
	assign found        = found_q;
	assign found_id     = found_id_q;
	assign found_handle = found_handle_q;
	assign entry_count  = entry_count_q;

endmodule

`default_nettype wire

/* hdl/bsft_checker.sv */
// ----------------------------------------------------------------------------
// bsft_checker
// Port-level checks on the sorted floor table, attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module bsft_checker
	import bsft_pkg::*;
#(
	parameter int CAPACITY = 16
) (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                start,
	input wire logic                busy,
	input wire logic                done,
	input wire logic                found,
	input wire logic [KEY_W-1:0]    found_id,
	input wire logic [HANDLE_W-1:0] found_handle,
	input wire logic [LIMIT_W-1:0]  entry_count
);

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted beat did not raise busy");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result beat while still busy");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("two result beats in a row");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !found |-> found_id == '0 && found_handle == '0)
		else $error("miss or put result carries nonzero payload");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> int'(entry_count) <= CAPACITY)
		else $error("entry count above capacity");

endmodule

bind bounded_sorted_floor_table bsft_checker #(.CAPACITY(CAPACITY)) u_bsft_checker (.*);

`default_nettype wire

/* dv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the bounded sorted floor table. A directed table
// covers the empty table, key extremes, handle replacement, a lowered limit,
// a zero limit and an over-range limit. Random puts and floor lookups follow,
// drawn from a small key pool so that replacement and eviction happen often,
// under several limits and sender idle rates. Every result is checked field by
// field against a fixed expectation or a sorted-queue predictor of the table.
// ----------------------------------------------------------------------------
module tb_top;
	import bsft_pkg::*;

	localparam int CAP = 16;
	localparam logic [KEY_W-1:0] KEY_MIN = 64'h8000_0000_0000_0000;
	localparam logic [KEY_W-1:0] KEY_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

	typedef struct packed {
		logic                hit;
		logic [KEY_W-1:0]    id;
		logic [HANDLE_W-1:0] hdl;
		logic [LIMIT_W-1:0]  cnt;
	} floor_result_t;

	typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

	typedef struct {
		row_kind_t           kind;
		logic                act;
		logic [KEY_W-1:0]    kv;
		logic [HANDLE_W-1:0] hv;
		bit                  chk;
		floor_result_t       res;
	} stim_row_t;

	logic                clk;
	logic                arst_n       = 1'b0;
	logic                start        = 1'b0;
	logic                action       = ACT_PUT;
	logic [KEY_W-1:0]    entry_key    = '0;
	logic [HANDLE_W-1:0] entry_handle = '0;
	logic                cfg_we       = 1'b0;
	logic [LIMIT_W-1:0]  cfg_wdata    = '0;
	logic                busy;
	logic                done;
	logic                found;
	logic [KEY_W-1:0]    found_id;
	logic [HANDLE_W-1:0] found_handle;
	logic [LIMIT_W-1:0]  entry_count;

	bsft_entry_t   held_q[$];
	int unsigned   limit_reg = LIMIT_RST;
	floor_result_t pending_q[$];
	stim_row_t     dir_rows[$];
	logic [KEY_W-1:0] key_pool[24];
	int            pool_n = 1;
	int            idle_pct = 0;
	int            err_cnt = 0;

	bounded_sorted_floor_table #(.CAPACITY(CAP)) DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.action      (action),
		.entry_key   (entry_key),
		.entry_handle(entry_handle),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.done        (done),
		.found       (found),
		.found_id    (found_id),
		.found_handle(found_handle),
		.entry_count (entry_count)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5000000;
		$display("DONE: errors detected");
		$finish;
	end

	function automatic floor_result_t table_apply(logic act, logic [KEY_W-1:0] kv,
			logic [HANDLE_W-1:0] hv);
		floor_result_t r;
		bsft_entry_t   e;
		int unsigned   lim;
		int            pos;
		r = '0;
		lim = (limit_reg > CAP) ? CAP : limit_reg;
		if (act == ACT_PUT) begin
			if (lim != 0) begin
				pos = 0;
				while (pos < held_q.size() && $signed(held_q[pos].key) < $signed(kv))
					pos++;
				if (pos < held_q.size() && held_q[pos].key == kv) begin
					held_q[pos].handle = hv;
				end else begin
					e.key = kv;
					e.handle = hv;
					held_q.insert(pos, e);
				end
				while (held_q.size() > lim)
					void'(held_q.pop_front());
			end
		end else begin
			foreach (held_q[i]) begin
				if ($signed(held_q[i].key) <= $signed(kv)) begin
					r.hit = 1'b1;
					r.id  = held_q[i].key;
					r.hdl = held_q[i].handle;
				end
			end
		end
		r.cnt = LIMIT_W'(held_q.size());
		return r;
	endfunction

	function automatic stim_row_t mk_row(row_kind_t k, logic act, logic [KEY_W-1:0] kv,
			logic [HANDLE_W-1:0] hv, bit chk, logic hit, logic [KEY_W-1:0] id,
			logic [HANDLE_W-1:0] h, logic [LIMIT_W-1:0] cnt);
		stim_row_t r;
		r.kind = k;
		r.act = act;
		r.kv = kv;
		r.hv = hv;
		r.chk = chk;
		r.res.hit = hit;
		r.res.id = id;
		r.res.hdl = h;
		r.res.cnt = cnt;
		return r;
	endfunction

	function automatic logic [KEY_W-1:0] pick_key();
		int r;
		logic [KEY_W-1:0] k;
		r = $urandom_range(0, 15);
		k = key_pool[$urandom_range(0, pool_n - 1)];
		if (r == 0)
			k = {$urandom, $urandom};
		else if (r == 1)
			k = KEY_MIN;
		else if (r == 2)
			k = KEY_MAX;
		else if (r < 6)
			k = k + 64'd1;
		else if (r < 9)
			k = k - 64'd1;
		return k;
	endfunction

	task automatic issue(input logic act, input logic [KEY_W-1:0] kv,
			input logic [HANDLE_W-1:0] hv, input bit chk, input floor_result_t fixed_res);
		floor_result_t r;
		int gap;
		start <= 1'b1;
		action <= act;
		entry_key <= kv;
		entry_handle <= hv;
		do @(posedge clk); while (busy);
		r = table_apply(act, kv, hv);
		pending_q.push_back(chk ? fixed_res : r);
		gap = 0;
		while (gap < 20 && $urandom_range(0, 99) < idle_pct)
			gap++;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain();
		start <= 1'b0;
		while (pending_q.size() != 0)
			@(posedge clk);
		repeat (24) @(posedge clk);
	endtask

	task automatic write_limit(input logic [LIMIT_W-1:0] v);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		limit_reg = v;
		cfg_we <= 1'b0;
	endtask

	// compare each beat with the oldest expectation
	always @(posedge clk) begin
		floor_result_t e;
		if (done) begin
			if (pending_q.size() == 0) begin
				if (err_cnt < 10)
					$display("unexpected result: found=%0b id=%h handle=%h count=%0d",
						found, found_id, found_handle, entry_count);
				err_cnt++;
			end else begin
				e = pending_q.pop_front();
				if (found !== e.hit || found_id !== e.id || found_handle !== e.hdl ||
						entry_count !== e.cnt) begin
					if (err_cnt < 10)
						$display("mismatch: exp found=%0b id=%h handle=%h count=%0d,",
							e.hit, e.id, e.hdl, e.cnt,
							" got found=%0b id=%h handle=%h count=%0d",
							found, found_id, found_handle, entry_count);
					err_cnt++;
				end
			end
		end
	end

	initial begin
		stim_row_t row;
		int lim_seq[8];
		int s;
		int r;
		lim_seq = '{16, 1, 0, 31, 17, 2, 16, 8};

		dir_rows.push_back(mk_row(ROW_ITEM, ACT_LOOKUP, 64'd0, 32'd0, 1, 0, 0, 0, 0));
		dir_rows.push_back(mk_row(ROW_ITEM, ACT_LOOKUP, KEY_MIN, 32'hFFFF_FFFF, 1, 0, 0, 0, 0));
		dir_rows.push_back(mk_row(ROW_ITEM, ACT_PUT, KEY_MAX, 32'hFFFF_FFFF, 1, 0, 0, 0, 1));
		dir_rows.push_back(mk_row(ROW_ITEM, ACT_PUT, KEY_MIN, 32'd0, 1, 0, 0, 0, 2));
		dir_rows.push_back(mk_row(ROW_ITEM, ACT_LOOKUP, KEY_MAX, 32'd0, 1,
			1, KEY_MAX, 32'hFFFF_FFFF, 2));
		dir_rows.push_back(mk_row(ROW_ITEM, ACT_LOOKUP, KEY_MIN, 32'd0, 1, 1, KEY_MIN, 0, 2));
		dir_rows.push_back(mk_row(ROW_ITEM, ACT_LOOKUP, '1, 32'd0, 1, 1, KEY_MIN, 0, 2));
		dir_rows.push_back(mk_row(ROW_ITEM, ACT_PUT, 64'd0, 32'h1234, 1, 0, 0, 0, 3));
		dir_rows.push_back(mk_row(ROW_ITEM, ACT_PUT, 64'd0, 32'hABCD, 1, 0, 0, 0, 3));
		dir_rows.push_back(mk_row(ROW_ITEM, ACT_LOOKUP, 64'd5, 32'd0, 1, 1, 0, 32'hABCD, 3));
		dir_rows.push_back(mk_row(ROW_CFG, ACT_PUT, 64'd0, 32'd2, 0, 0, 0, 0, 0));
		dir_rows.push_back(mk_row(ROW_ITEM, ACT_LOOKUP, KEY_MAX, 32'd0, 1,
			1, KEY_MAX, 32'hFFFF_FFFF, 3));
		dir_rows.push_back(mk_row(ROW_ITEM, ACT_PUT, 64'd10, 32'h77, 1, 0, 0, 0, 2));
		dir_rows.push_back(mk_row(ROW_ITEM, ACT_LOOKUP, 64'd9, 32'd0, 1, 0, 0, 0, 2));
		dir_rows.push_back(mk_row(ROW_ITEM, ACT_PUT, KEY_MIN, 32'h5, 1, 0, 0, 0, 2));
		dir_rows.push_back(mk_row(ROW_ITEM, ACT_LOOKUP, 64'd10, 32'd0, 1, 1, 64'd10, 32'h77, 2));
		dir_rows.push_back(mk_row(ROW_CFG, ACT_PUT, 64'd0, 32'd0, 0, 0, 0, 0, 0));
		dir_rows.push_back(mk_row(ROW_ITEM, ACT_PUT, 64'd3, 32'h9, 1, 0, 0, 0, 2));
		dir_rows.push_back(mk_row(ROW_ITEM, ACT_LOOKUP, 64'd3, 32'd0, 1, 0, 0, 0, 2));
		dir_rows.push_back(mk_row(ROW_CFG, ACT_PUT, 64'd0, 32'd31, 0, 0, 0, 0, 0));
		dir_rows.push_back(mk_row(ROW_ITEM, ACT_PUT, -64'sd5, 32'h1, 0, 0, 0, 0, 0));
		dir_rows.push_back(mk_row(ROW_ITEM, ACT_LOOKUP, -64'sd3, 32'd0, 0, 0, 0, 0, 0));
		dir_rows.push_back(mk_row(ROW_ITEM, ACT_LOOKUP, KEY_MAX - 64'd1, 32'd0, 0, 0, 0, 0, 0));

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		idle_pct = 15;
		foreach (dir_rows[i]) begin
			row = dir_rows[i];
			if (row.kind == ROW_CFG)
				write_limit(row.hv[LIMIT_W-1:0]);
			else
				issue(row.act, row.kv, row.hv, row.chk, row.res);
		end

		for (int phase = 0; phase < 3; phase++) begin
			idle_pct = (phase == 0) ? 15 : (phase == 1) ? 64 : 0;
			for (int seg = 0; seg < 6; seg++) begin
				s = phase * 6 + seg;
				write_limit(LIMIT_W'((s < 8) ? lim_seq[s] : $urandom_range(0, 31)));
				pool_n = $urandom_range(2, 24);
				for (int k = 0; k < pool_n; k++) begin
					r = $urandom_range(0, 5);
					if (r == 0)
						key_pool[k] = KEY_W'(int'($urandom_range(0, 100)) - 50);
					else if (r == 1)
						key_pool[k] = KEY_MIN + KEY_W'($urandom_range(0, 20));
					else if (r == 2)
						key_pool[k] = KEY_MAX - KEY_W'($urandom_range(0, 20));
					else
						key_pool[k] = {$urandom, $urandom};
				end
				for (int n = 0; n < 102; n++) begin
					if ($urandom_range(0, 63) == 0)
						drain();
					issue(($urandom_range(0, 99) < 55) ? ACT_PUT : ACT_LOOKUP,
						pick_key(), $urandom, 0, '0);
				end
			end
		end

		drain();
		if (err_cnt == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

/* filelist.f */
hdl/bsft_pkg.sv
hdl/bsft_cell.sv
hdl/bounded_sorted_floor_table.sv
hdl/bsft_checker.sv
dv/tb_top.sv
